/* rtl/hcs_pkg.sv */
// Shared constants, types and the square-root step for the hollow cylinder SDF core.
package hcs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int RADIUS_W      = 31;
    localparam int SHIFT_W       = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int SQ_W          = 64;
    localparam int ROOT_W        = 32;
    localparam int SQRT_STAGES   = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_RADIUS = 1'b0,
        CFG_STEP_SHIFT   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sq_st;

    // One iteration of the digit-by-digit integer square root.
    function automatic t_sq_st sqrt_step(t_sq_st s, logic [SQ_W-1:0] b);
        logic [SQ_W:0] t;
        t_sq_st        o;
        t = {1'b0, s.r} + {1'b0, b};
        if ({1'b0, s.v} >= t) begin
            o.v = s.v - t[SQ_W-1:0];
            o.r = (s.r >> 1) + b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage

/* rtl/hcs_if.sv */
// Handshake channel interfaces: query point, result and configuration write.
interface hcs_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [hcs_pkg::COORD_W-1:0]  point_x;
    logic signed [hcs_pkg::COORD_W-1:0]  point_y;
    logic signed [hcs_pkg::COORD_W-1:0]  point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface hcs_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [hcs_pkg::COORD_W-1:0]  signed_distance;
    logic signed [hcs_pkg::COORD_W-1:0]  grad_x;
    logic signed [hcs_pkg::COORD_W-1:0]  grad_y;
    logic signed [hcs_pkg::COORD_W-1:0]  grad_z;
    modport source (output valid, signed_distance, grad_x, grad_y, grad_z, input ready);
    modport sink   (input valid, signed_distance, grad_x, grad_y, grad_z, output ready);
endinterface

interface hcs_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [hcs_pkg::CFG_IDX_W-1:0]        index;
    logic [hcs_pkg::CFG_DATA_W-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/hcs_isqrt.sv */
// Pipelined multi-lane 64-bit integer square root, one result bit per stage.
module hcs_isqrt #(
    parameter int LANES = 1,
    parameter int TAG_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [hcs_pkg::SQ_W-1:0]     i_val [LANES],
    input  logic [TAG_W-1:0]             i_tag,
    output logic                         o_valid,
    output logic [hcs_pkg::ROOT_W-1:0]   o_root [LANES],
    output logic [TAG_W-1:0]             o_tag
);
    localparam int NS = hcs_pkg::SQRT_STAGES;

    hcs_pkg::t_sq_st  r_st  [NS+1][LANES];
    logic [TAG_W-1:0] r_tag [NS+1];
    logic             r_vld [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int l = 0; l < LANES; l++) begin
                r_st[0][l].v <= i_val[l];
                r_st[0][l].r <= '0;
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [hcs_pkg::SQ_W-1:0] BIT = hcs_pkg::SQ_W'(1) << (hcs_pkg::SQ_W - 2 - 2*k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k+1] <= r_tag[k];
                for (int l = 0; l < LANES; l++) begin
                    r_st[k+1][l] <= hcs_pkg::sqrt_step(r_st[k][l], BIT);
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_st[NS][l].r[hcs_pkg::ROOT_W-1:0];
        end
    end

    assign o_valid = r_vld[NS];
    assign o_tag   = r_tag[NS];

endmodule

/* rtl/hollow_cylinder_sdf_gradient_core.sv */
// Top level: hollow cylinder signed distance and forward-difference gradient pipeline.
// Takes one query point per cycle unless the result side stalls, and returns one result per
// point. Data passes through two square-root pipelines in series (radial distance,
// then corner distance), each an input register followed by 32 stages that produce one
// root bit per stage, plus eight stages of input, offset, squaring, selection and
// saturation. The three shifted evaluations run in parallel lanes beside the centre one.
// A stall on the result side holds the whole pipeline. Configuration writes are taken at
// any time but must only be issued while no point is in flight.
module hollow_cylinder_sdf_gradient_core #(
    parameter int FRAC_BITS = hcs_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcs_pt_if.sink    i_pt,
    hcs_cfg_if.sink   i_cfg,
    hcs_res_if.source o_res
);
    localparam int CW  = hcs_pkg::COORD_W;
    localparam int DW  = 34;
    localparam int RT  = 2 * CW;
    localparam int CT  = 4 + 4 * DW;

    function automatic logic [CW-1:0] mag33(logic signed [CW:0] v);
        logic [CW:0] m;
        m = v[CW] ? 33'(-v) : 33'(v);
        return m[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[CW-1:0];
        end
    endfunction

    // configuration
    logic [hcs_pkg::RADIUS_W-1:0] r_outer_radius;
    logic [hcs_pkg::SHIFT_W-1:0]  r_step_shift;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_radius <= hcs_pkg::RADIUS_RST;
            r_step_shift   <= hcs_pkg::SHIFT_RST;
        end else if (i_cfg.valid) begin
            case (hcs_pkg::t_cfg_reg'(i_cfg.index))
                hcs_pkg::CFG_OUTER_RADIUS: r_outer_radius <= i_cfg.data[hcs_pkg::RADIUS_W-1:0];
                hcs_pkg::CFG_STEP_SHIFT:   r_step_shift   <= i_cfg.data[hcs_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [hcs_pkg::SHIFT_W-1:0] w_s;
    logic [CW:0]                 w_h;
    assign w_s = (r_step_shift > hcs_pkg::SHIFT_W'(FRAC_BITS)) ?
                 hcs_pkg::SHIFT_W'(FRAC_BITS) : r_step_shift;
    assign w_h = 33'(1) << (hcs_pkg::SHIFT_W'(FRAC_BITS) - w_s);

    // global advance
    logic r8_vld;
    logic w_en;
    assign w_en       = !r8_vld || o_res.ready;
    assign i_pt.ready = w_en;

    // P1: input register
    logic                 r1_vld;
    logic signed [CW-1:0] r1_x, r1_y, r1_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (w_en) r1_vld <= i_pt.valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x <= i_pt.point_x;
            r1_y <= i_pt.point_y;
            r1_z <= i_pt.point_z;
        end
    end

    // P2: shifted coordinates and magnitudes
    logic          r2_vld;
    logic [CW-1:0] r2_mx, r2_mxs, r2_my, r2_mys, r2_mz, r2_mzs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (w_en) r2_vld <= r1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mx  <= mag33($signed({r1_x[CW-1], r1_x}));
            r2_my  <= mag33($signed({r1_y[CW-1], r1_y}));
            r2_mz  <= mag33($signed({r1_z[CW-1], r1_z}));
            r2_mxs <= mag33($signed({r1_x[CW-1], r1_x}) + $signed(w_h));
            r2_mys <= mag33($signed({r1_y[CW-1], r1_y}) + $signed(w_h));
            r2_mzs <= mag33($signed({r1_z[CW-1], r1_z}) + $signed(w_h));
        end
    end

    // P3: squares
    logic            r3_vld;
    logic [RT-1:0]   r3_sx, r3_sxs, r3_sy, r3_sys;
    logic [CW-1:0]   r3_mz, r3_mzs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (w_en) r3_vld <= r2_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sx  <= r2_mx * r2_mx;
            r3_sxs <= r2_mxs * r2_mxs;
            r3_sy  <= r2_my * r2_my;
            r3_sys <= r2_mys * r2_mys;
            r3_mz  <= r2_mz;
            r3_mzs <= r2_mzs;
        end
    end

    // radial roots: lane 0 centre (also the z-shifted case), 1 x-shifted, 2 y-shifted
    logic [hcs_pkg::SQ_W-1:0]   w_rad_in   [3];
    logic [hcs_pkg::ROOT_W-1:0] w_rad_root [3];
    logic [2*CW-1:0]            w_rad_tag;
    logic                       w_rad_vld;
    assign w_rad_in[0] = r3_sx + r3_sy;
    assign w_rad_in[1] = r3_sxs + r3_sy;
    assign w_rad_in[2] = r3_sx + r3_sys;

    hcs_isqrt #(.LANES(3), .TAG_W(2*CW)) u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_vld),
        .i_val   (w_rad_in),
        .i_tag   ({r3_mz, r3_mzs}),
        .o_valid (w_rad_vld),
        .o_root  (w_rad_root),
        .o_tag   (w_rad_tag)
    );

    // P4: wall and cap offsets, cases centre, +x, +y, +z
    logic                 r4_vld;
    logic signed [DW-1:0] r4_od [4];
    logic signed [DW-1:0] r4_id [4];
    logic signed [DW-1:0] r4_zd [4];
    logic [CW-1:0]        w_xy  [4];
    logic [CW-1:0]        w_mzc [4];
    always_comb begin
        w_xy[0]  = w_rad_root[0];
        w_xy[1]  = w_rad_root[1];
        w_xy[2]  = w_rad_root[2];
        w_xy[3]  = w_rad_root[0];
        w_mzc[0] = w_rad_tag[2*CW-1:CW];
        w_mzc[1] = w_rad_tag[2*CW-1:CW];
        w_mzc[2] = w_rad_tag[2*CW-1:CW];
        w_mzc[3] = w_rad_tag[CW-1:0];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else if (w_en) r4_vld <= w_rad_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r4_od[c] <= $signed({2'b00, w_xy[c]}) - $signed({3'b000, r_outer_radius});
                r4_id[c] <= $signed({4'b0000, r_outer_radius[hcs_pkg::RADIUS_W-1:1]})
                            - $signed({2'b00, w_xy[c]});
                r4_zd[c] <= $signed({2'b00, w_mzc[c]}) - $signed({3'b000, r_outer_radius});
            end
        end
    end

    // P5: region select
    logic                 r5_vld;
    logic [3:0]           r5_use;
    logic [CW-1:0]        r5_a   [4];
    logic [CW-1:0]        r5_b   [4];
    logic signed [DW-1:0] r5_alt [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else if (w_en) r5_vld <= r4_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r5_use[c] <= (r4_zd[c] > 34'sd0) && ((r4_od[c] > 34'sd0) || (r4_id[c] > 34'sd0));
                r5_a[c]   <= (r4_od[c] > 34'sd0) ? r4_od[c][CW-1:0] : r4_id[c][CW-1:0];
                r5_b[c]   <= r4_zd[c][CW-1:0];
                if (r4_zd[c] > 34'sd0) begin
                    r5_alt[c] <= r4_zd[c];
                end else begin
                    r5_alt[c] <= (r4_od[c] > r4_id[c]) ? r4_od[c] : r4_id[c];
                end
            end
        end
    end

    // P6: corner squares
    logic                 r6_vld;
    logic [3:0]           r6_use;
    logic [RT-1:0]        r6_sa  [4];
    logic [RT-1:0]        r6_sb  [4];
    logic signed [DW-1:0] r6_alt [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else if (w_en) r6_vld <= r5_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_use <= r5_use;
            for (int c = 0; c < 4; c++) begin
                r6_sa[c]  <= r5_a[c] * r5_a[c];
                r6_sb[c]  <= r5_b[c] * r5_b[c];
                r6_alt[c] <= r5_alt[c];
            end
        end
    end

    logic [hcs_pkg::SQ_W-1:0]   w_cor_in   [4];
    logic [hcs_pkg::ROOT_W-1:0] w_cor_root [4];
    logic [CT-1:0]              w_cor_tag_i;
    logic [CT-1:0]              w_cor_tag;
    logic                       w_cor_vld;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_cor_in[c] = r6_sa[c] + r6_sb[c];
        end
        w_cor_tag_i = {r6_use, r6_alt[3], r6_alt[2], r6_alt[1], r6_alt[0]};
    end

    hcs_isqrt #(.LANES(4), .TAG_W(CT)) u_cor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_vld),
        .i_val   (w_cor_in),
        .i_tag   (w_cor_tag_i),
        .o_valid (w_cor_vld),
        .o_root  (w_cor_root),
        .o_tag   (w_cor_tag)
    );

    // P7: distances and differences
    logic signed [DW-1:0] w_d [4];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_d[c] = w_cor_tag[4*DW + c] ? $signed({2'b00, w_cor_root[c]})
                                          : $signed(w_cor_tag[c*DW +: DW]);
        end
    end

    logic                 r7_vld;
    logic signed [DW-1:0] r7_d0;
    logic signed [DW:0]   r7_diff [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_vld <= 1'b0;
        else if (w_en) r7_vld <= w_cor_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_d0 <= w_d[0];
            for (int c = 0; c < 3; c++) begin
                r7_diff[c] <= $signed({w_d[c+1][DW-1], w_d[c+1]}) - $signed({w_d[0][DW-1], w_d[0]});
            end
        end
    end

    // P8: scale and saturate into the output register
    logic [CW-1:0] r8_dist, r8_gx, r8_gy, r8_gz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_vld <= 1'b0;
        else if (w_en) r8_vld <= r7_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_dist <= sat32($signed({{(64-DW){r7_d0[DW-1]}}, r7_d0}));
            r8_gx   <= sat32($signed({{(63-DW){r7_diff[0][DW]}}, r7_diff[0]}) <<< w_s);
            r8_gy   <= sat32($signed({{(63-DW){r7_diff[1][DW]}}, r7_diff[1]}) <<< w_s);
            r8_gz   <= sat32($signed({{(63-DW){r7_diff[2][DW]}}, r7_diff[2]}) <<< w_s);
        end
    end

    assign o_res.valid           = r8_vld;
    assign o_res.signed_distance = r8_dist;
    assign o_res.grad_x          = r8_gx;
    assign o_res.grad_y          = r8_gy;
    assign o_res.grad_z          = r8_gz;

`ifndef SYNTHESIS
    // the three non-z cases share one cap offset
    a_shared_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld |-> (r4_zd[0] == r4_zd[1]) && (r4_zd[1] == r4_zd[2]))
        else $error("cap offsets differ between lanes");

    // a corner root is only taken for a strictly positive wall offset
    a_corner_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_vld && r5_use[0]) |-> (r5_a[0] != '0) && (r5_b[0] != '0))
        else $error("corner selected with non-positive offset");

    // a held pipeline keeps its late stages
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r7_vld) |=> $stable(r7_d0) && r7_vld)
        else $error("stage 7 changed while stalled");
`endif

endmodule

/* bench/tb_hollow_cylinder_sdf_gradient_core.sv */
// Testbench for the hollow cylinder SDF and gradient core: checks every result against a predictor.
`timescale 1ns / 100ps

module tb_hollow_cylinder_sdf_gradient_core;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef struct packed {
        logic signed [31:0] distance;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
    } t_result;

    localparam int LATENCY  = 74;
    localparam int HOLD_LEN = 300;

    logic i_clk;
    logic i_rst_n;

    hcs_pt_if  pt_ch ();
    hcs_cfg_if cfg_ch ();
    hcs_res_if res_ch ();

    hollow_cylinder_sdf_gradient_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_res  (res_ch.source)
    );

    logic [30:0] radius;
    logic [4:0]  step_sh;
    t_point      point_q[$];
    t_result     expected_q[$];
    int          n_fail;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    logic        pt_taken = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag(longint a);
        return a < 0 ? longint'(0) - a : a;
    endfunction

    function automatic longint unsigned hyp(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        ma = mag(a);
        mb = mag(b);
        return root_floor(ma * ma + mb * mb);
    endfunction

    function automatic longint cylinder_dist(longint x, longint y, longint z);
        longint r;
        longint rin;
        longint xy;
        longint od;
        longint id;
        longint zd;
        r = longint'(radius);
        rin = r >>> 1;
        xy = longint'(hyp(x, y));
        od = xy - r;
        id = rin - xy;
        zd = longint'(mag(z)) - r;
        if (zd > 0) begin
            if (od > 0) return longint'(hyp(od, zd));
            if (id > 0) return longint'(hyp(id, zd));
            return zd;
        end
        return od > id ? od : id;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_result predict_result(t_point p);
        int      s;
        longint  h;
        longint  d0;
        longint  dx;
        longint  dy;
        longint  dz;
        t_result o;
        s = step_sh > 16 ? 16 : int'(step_sh);
        h = longint'(1) << (16 - s);
        d0 = cylinder_dist(p.x, p.y, p.z);
        dx = cylinder_dist(longint'(p.x) + h, p.y, p.z);
        dy = cylinder_dist(p.x, longint'(p.y) + h, p.z);
        dz = cylinder_dist(p.x, p.y, longint'(p.z) + h);
        o.distance = clip32(d0);
        o.gx = clip32((dx - d0) <<< s);
        o.gy = clip32((dy - d0) <<< s);
        o.gz = clip32((dz - d0) <<< s);
        return o;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_ch.valid <= 1'b0;
        end else if (!pt_ch.valid || pt_taken) begin
            if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                pt_ch.valid   <= 1'b1;
                pt_ch.point_x <= point_q[0].x;
                pt_ch.point_y <= point_q[0].y;
                pt_ch.point_z <= point_q[0].z;
            end else begin
                pt_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            res_ch.ready <= 1'b0;
            hold_ack <= hold_req;
            hold_cycles <= HOLD_LEN - 1;
        end else if (hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            res_ch.ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        pt_taken <= i_rst_n && pt_ch.valid && pt_ch.ready;
        if (i_rst_n && pt_ch.valid && pt_ch.ready) begin
            expected_q.push_back(predict_result({pt_ch.point_x, pt_ch.point_y, pt_ch.point_z}));
            void'(point_q.pop_front());
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.signed_distance, res_ch.grad_x, res_ch.grad_y, res_ch.grad_z};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                if (got.distance !== want.distance)
                    $display("%0t: distance expected %0d got %0d", $time, want.distance,
                             got.distance);
                if (got.gx !== want.gx)
                    $display("%0t: grad_x expected %0d got %0d", $time, want.gx, got.gx);
                if (got.gy !== want.gy)
                    $display("%0t: grad_y expected %0d got %0d", $time, want.gy, got.gy);
                if (got.gz !== want.gz)
                    $display("%0t: grad_z expected %0d got %0d", $time, want.gz, got.gz);
                if (got !== want) n_fail++;
            end
        end
    end

    task automatic write_reg(hcs_pkg::t_cfg_reg idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == hcs_pkg::CFG_OUTER_RADIUS) radius = val[30:0];
        else step_sh = val[4:0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (point_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(logic [30:0] r);
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(0, 2 * r + 3)) - 32'(r + 1);
            2: return $urandom_range(0, 3) ? r + $urandom_range(0, 4) - 2
                                           : (r >> 1) + $urandom_range(0, 4) - 2;
            3: return -(r + $urandom_range(0, 4) - 2);
            4: return {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom)};
            default: return 32'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_q.push_back({x, y, z});
    endtask

    task automatic random_points(int n);
        logic [30:0] r;
        r = radius;
        for (int i = 0; i < n; i++) push_point(rand_coord(r), rand_coord(r), rand_coord(r));
    endtask

    initial begin
        logic [30:0] radii[6];
        logic [4:0]  shifts[6];
        n_fail = 0;
        send_idle_pct = 19;
        recv_idle_pct = 47;
        radius = hcs_pkg::RADIUS_RST;
        step_sh = hcs_pkg::SHIFT_RST;
        i_rst_n = 1'b0;
        pt_ch.valid = 1'b0;
        pt_ch.point_x = '0;
        pt_ch.point_y = '0;
        pt_ch.point_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = hcs_pkg::CFG_OUTER_RADIUS;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: origin, walls, caps, corners, extremes at reset config
        push_point(0, 0, 0);
        push_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        push_point(32'h80000000, 32'h80000000, 32'h80000000);
        push_point(32'h7fffffff, 32'h80000000, 0);
        push_point(65536, 0, 0);
        push_point(32768, 0, 0);
        push_point(49152, 0, 0);
        push_point(0, 0, 65536);
        push_point(0, 0, -65536);
        push_point(131072, 0, 131072);
        push_point(16384, 0, 131072);
        push_point(49152, 0, 131072);
        push_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
        push_point(32'h55555555, 32'haaaaaaaa, 32'h5a5a5a5a);
        drain();
        write_reg(hcs_pkg::CFG_STEP_SHIFT, 31);
        push_point(32'h7fffffff, 0, 0);
        push_point(0, 32'h7fffffff, 32'h7fffffff);
        drain();
        write_reg(hcs_pkg::CFG_OUTER_RADIUS, 0);
        write_reg(hcs_pkg::CFG_STEP_SHIFT, 0);
        push_point(0, 0, 0);
        push_point(1, 0, 1);
        push_point(32'h80000000, 0, 32'h7fffffff);
        drain();

        radii  = '{31'h40000000, 31'd1, 31'h7fffffff, 31'd65536, 31'd3000, 31'd200000};
        shifts = '{5'd0, 5'd16, 5'd8, 5'd17, 5'd31, 5'd4};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 47;
                recv_idle_pct = 19;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(hcs_pkg::CFG_OUTER_RADIUS, radii[ph]);
            write_reg(hcs_pkg::CFG_STEP_SHIFT, shifts[ph]);
            random_points(190);
            if (ph == 3) begin
                @(negedge i_clk);
                hold_req = ~hold_req;
            end
            drain();
        end
        if (n_fail == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

/* files.f */
rtl/hcs_pkg.sv
rtl/hcs_if.sv
rtl/hcs_isqrt.sv
rtl/hollow_cylinder_sdf_gradient_core.sv
bench/tb_hollow_cylinder_sdf_gradient_core.sv
